// ===== rtl/spea_pkg.sv =====
package spea_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int IN_BITS     = 16;
  localparam int SQ_BITS     = 48;
  localparam int VALUE_BITS  = 22;
  localparam int HSUM_BITS   = VALUE_BITS + COUNT_BITS;
  localparam int ROOT_BITS   = SQ_BITS / 2;
  localparam int REM_BITS    = ROOT_BITS + 3;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int ADD_BITS    = ((PROD_BITS > SQ_BITS) ? PROD_BITS : SQ_BITS) + 1;
  localparam int SQRT_STEPS  = ROOT_BITS;
  localparam int DIV_STEPS   = HSUM_BITS;
  localparam int MAX_STEPS   = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
  localparam int STEP_BITS   = $clog2(MAX_STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_AVG   = 1'b1;

  typedef enum logic [1:0] {
    JOB_FRAME,
    JOB_REPORT,
    JOB_CLEAR
  } job_op_e;

  typedef struct packed {
    job_op_e             op;
    logic [SQ_BITS-1:0]  sum;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_HIST,
    ST_DIV,
    ST_EMIT
  } back_state_e;

endpackage

// ===== rtl/spea_queue.sv =====
module spea_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  spea_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output spea_pkg::job_t job_o,
  output logic           empty_o
);

  spea_pkg::job_t                     entry_q [spea_pkg::QUEUE_DEPTH];
  logic [spea_pkg::QPTR_BITS-1:0]     wr_ptr_q, wr_ptr_d;
  logic [spea_pkg::QPTR_BITS-1:0]     rd_ptr_q, rd_ptr_d;
  logic [spea_pkg::QCNT_BITS-1:0]     cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign full_o  = (cnt_q == spea_pkg::QCNT_BITS'(spea_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == spea_pkg::QPTR_BITS'(spea_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == spea_pkg::QPTR_BITS'(spea_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/spea_front.sv =====
module spea_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [1:0]                    command_i,
  input  logic [spea_pkg::IN_BITS-1:0]  intensity_i,
  input  logic                          last_i,
  output logic                          q_push_o,
  output spea_pkg::job_t                q_job_o
);

  logic [spea_pkg::SAMPLE_BITS-1:0] older_q, older_d;
  logic [spea_pkg::SAMPLE_BITS-1:0] newer_q, newer_d;
  logic [spea_pkg::PROD_BITS-1:0]   newer_sq_q, newer_sq_d;
  logic [1:0]                       seen_q, seen_d;
  logic [spea_pkg::SQ_BITS-1:0]     sum_q, sum_d;
  logic [spea_pkg::SAMPLE_BITS-1:0] sample;
  logic [spea_pkg::ADD_BITS-1:0]    sum_ext;
  logic [spea_pkg::SQ_BITS-1:0]     sum_next;
  logic                             peak;
  logic                             is_sample;

  assign sample    = spea_pkg::SAMPLE_BITS'(intensity_i);
  assign is_sample = (command_i == spea_pkg::CMD_SAMPLE);
  assign peak      = seen_q[1] && (newer_q > older_q) && (newer_q > sample);

  // saturating frame accumulator
  always_comb begin
    sum_ext = spea_pkg::ADD_BITS'(sum_q)
            + (peak ? spea_pkg::ADD_BITS'(newer_sq_q) : '0);
    if (sum_ext[spea_pkg::ADD_BITS-1:spea_pkg::SQ_BITS] != '0) begin
      sum_next = '1;
    end else begin
      sum_next = sum_ext[spea_pkg::SQ_BITS-1:0];
    end
  end

  always_comb begin
    older_d    = older_q;
    newer_d    = newer_q;
    newer_sq_d = newer_sq_q;
    seen_d     = seen_q;
    sum_d      = sum_q;
    q_push_o   = 1'b0;
    q_job_o.op  = spea_pkg::JOB_FRAME;
    q_job_o.sum = sum_next;
    if (accept_i) begin
      case (command_i)
        spea_pkg::CMD_SAMPLE: begin
          if (last_i) begin
            q_push_o   = 1'b1;
            older_d    = '0;
            newer_d    = '0;
            newer_sq_d = '0;
            seen_d     = '0;
            sum_d      = '0;
          end else begin
            older_d    = newer_q;
            newer_d    = sample;
            newer_sq_d = sample * sample;
            seen_d     = seen_q[1] ? seen_q : seen_q + 1'b1;
            sum_d      = sum_next;
          end
        end
        spea_pkg::CMD_REPORT: begin
          q_push_o   = 1'b1;
          q_job_o.op = spea_pkg::JOB_REPORT;
        end
        spea_pkg::CMD_CLEAR: begin
          q_push_o   = 1'b1;
          q_job_o.op = spea_pkg::JOB_CLEAR;
        end
        default: begin
          q_push_o = 1'b0;
        end
      endcase
    end
    if (!is_sample) begin
      q_job_o.sum = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q    <= '0;
      newer_q    <= '0;
      newer_sq_q <= '0;
      seen_q     <= '0;
      sum_q      <= '0;
    end else begin
      older_q    <= older_d;
      newer_q    <= newer_d;
      newer_sq_q <= newer_sq_d;
      seen_q     <= seen_d;
      sum_q      <= sum_d;
    end
  end

endmodule

// ===== rtl/spea_back.sv =====
module spea_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  spea_pkg::job_t                  q_job_i,
  input  logic                            q_empty_i,
  output logic                            q_pop_o,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic                            kind_o,
  output logic [spea_pkg::VALUE_BITS-1:0] value_o,
  output logic                            frame_counted_o
);

  spea_pkg::back_state_e state_q, state_d;

  logic [spea_pkg::SQ_BITS-1:0]    x_q, x_d;
  logic [spea_pkg::REM_BITS-1:0]   rem_q, rem_d;
  logic [spea_pkg::ROOT_BITS-1:0]  root_q, root_d;
  logic [spea_pkg::HSUM_BITS-1:0]  dvd_q, dvd_d;
  logic [spea_pkg::COUNT_BITS-1:0] drem_q, drem_d;
  logic [spea_pkg::STEP_BITS-1:0]  step_q, step_d;
  logic [spea_pkg::HSUM_BITS-1:0]  hsum_q, hsum_d;
  logic [spea_pkg::COUNT_BITS-1:0] hcnt_q, hcnt_d;
  logic                            res_kind_q, res_kind_d;
  logic [spea_pkg::VALUE_BITS-1:0] res_value_q, res_value_d;
  logic                            res_counted_q, res_counted_d;
  logic                            out_valid_q, out_valid_d;
  logic                            kind_q;
  logic [spea_pkg::VALUE_BITS-1:0] value_q;
  logic                            counted_q;

  logic                            out_load;
  logic [spea_pkg::REM_BITS-1:0]   rem_sh;
  logic [spea_pkg::REM_BITS-1:0]   trial;
  logic                            rem_ge;
  logic [spea_pkg::COUNT_BITS:0]   drem_sh;
  logic                            drem_ge;
  logic [spea_pkg::VALUE_BITS-1:0] frame_value;
  logic                            frame_ok;
  logic                            last_sqrt;
  logic                            last_div;

  // one root digit per cycle
  assign rem_sh = {rem_q[spea_pkg::REM_BITS-3:0], x_q[spea_pkg::SQ_BITS-1 -: 2]};
  assign trial  = spea_pkg::REM_BITS'({root_q, 2'b01});
  assign rem_ge = (rem_sh >= trial);

  // one quotient bit per cycle
  assign drem_sh = {drem_q, dvd_q[spea_pkg::HSUM_BITS-1]};
  assign drem_ge = (drem_sh >= {1'b0, hcnt_q});

  assign last_sqrt = (step_q == spea_pkg::STEP_BITS'(spea_pkg::SQRT_STEPS - 1));
  assign last_div  = (step_q == spea_pkg::STEP_BITS'(spea_pkg::DIV_STEPS - 1));

  assign frame_value = (root_q[spea_pkg::ROOT_BITS-1:spea_pkg::VALUE_BITS] != '0) ? '1
                       : root_q[spea_pkg::VALUE_BITS-1:0];
  assign frame_ok    = (frame_value != '0) && !(&hcnt_q);

  assign out_load = (state_q == spea_pkg::ST_EMIT) && (!out_valid_q || pop_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spea_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          case (q_job_i.op)
            spea_pkg::JOB_FRAME:  state_d = spea_pkg::ST_SQRT;
            spea_pkg::JOB_REPORT: state_d = (hcnt_q == '0) ? spea_pkg::ST_EMIT
                                                           : spea_pkg::ST_DIV;
            default:              state_d = spea_pkg::ST_IDLE;
          endcase
        end
      end
      spea_pkg::ST_SQRT: begin
        if (last_sqrt) begin
          state_d = spea_pkg::ST_HIST;
        end
      end
      spea_pkg::ST_HIST: begin
        state_d = spea_pkg::ST_EMIT;
      end
      spea_pkg::ST_DIV: begin
        if (last_div) begin
          state_d = spea_pkg::ST_EMIT;
        end
      end
      spea_pkg::ST_EMIT: begin
        if (out_load) begin
          state_d = spea_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spea_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop_o       = 1'b0;
    x_d           = x_q;
    rem_d         = rem_q;
    root_d        = root_q;
    dvd_d         = dvd_q;
    drem_d        = drem_q;
    step_d        = step_q;
    hsum_d        = hsum_q;
    hcnt_d        = hcnt_q;
    res_kind_d    = res_kind_q;
    res_value_d   = res_value_q;
    res_counted_d = res_counted_q;
    case (state_q)
      spea_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          step_d  = '0;
          case (q_job_i.op)
            spea_pkg::JOB_FRAME: begin
              x_d    = q_job_i.sum;
              rem_d  = '0;
              root_d = '0;
            end
            spea_pkg::JOB_REPORT: begin
              dvd_d         = hsum_q;
              drem_d        = '0;
              res_kind_d    = spea_pkg::KIND_AVG;
              res_value_d   = '0;
              res_counted_d = 1'b0;
            end
            default: begin
              hsum_d = '0;
              hcnt_d = '0;
            end
          endcase
        end
      end
      spea_pkg::ST_SQRT: begin
        x_d    = {x_q[spea_pkg::SQ_BITS-3:0], 2'b00};
        step_d = step_q + 1'b1;
        if (rem_ge) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[spea_pkg::ROOT_BITS-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[spea_pkg::ROOT_BITS-2:0], 1'b0};
        end
      end
      spea_pkg::ST_HIST: begin
        res_kind_d    = spea_pkg::KIND_FRAME;
        res_value_d   = frame_value;
        res_counted_d = frame_ok;
        if (frame_ok) begin
          hsum_d = hsum_q + spea_pkg::HSUM_BITS'(frame_value);
          hcnt_d = hcnt_q + 1'b1;
        end
      end
      spea_pkg::ST_DIV: begin
        step_d = step_q + 1'b1;
        if (drem_ge) begin
          drem_d = spea_pkg::COUNT_BITS'(drem_sh - {1'b0, hcnt_q});
        end else begin
          drem_d = drem_sh[spea_pkg::COUNT_BITS-1:0];
        end
        dvd_d = {dvd_q[spea_pkg::HSUM_BITS-2:0], drem_ge};
        if (last_div) begin
          res_value_d = dvd_d[spea_pkg::VALUE_BITS-1:0];
        end
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  assign empty_o         = !out_valid_q;
  assign kind_o          = kind_q;
  assign value_o         = value_q;
  assign frame_counted_o = counted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= spea_pkg::ST_IDLE;
      step_q        <= '0;
      hsum_q        <= '0;
      hcnt_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      step_q        <= step_d;
      hsum_q        <= hsum_d;
      hcnt_q        <= hcnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q           <= x_d;
    rem_q         <= rem_d;
    root_q        <= root_d;
    dvd_q         <= dvd_d;
    drem_q        <= drem_d;
    res_kind_q    <= res_kind_d;
    res_value_q   <= res_value_d;
    res_counted_q <= res_counted_d;
    if (out_load) begin
      kind_q    <= res_kind_q;
      value_q   <= res_value_q;
      counted_q <= res_counted_q;
    end
  end

endmodule

// ===== rtl/spectrum_peak_energy_average.sv =====
// spectrum peak energy average
// input channel: one word per accepted push (push high, full low) carrying
//   command_i, intensity_i and last_i; samples may arrive every cycle
// result channel: the oldest word sits on kind_o, value_o and frame_counted_o
//   while empty is low and leaves on a cycle with pop high
// the front tracks the last two samples, squares the newer one and adds it
//   to the frame sum when it turns out to be a peak; a frame end, a report or
//   a clear goes into a two-entry job queue for the back end
// throughput: one sample per cycle; the front stalls only when the job queue
//   is full, which needs frame ends or commands closer together than the
//   back end finishes them
// a frame result passes through a queue pop, the root digits, a history
//   update and an output load; a report runs a restoring divide in place of
//   the root and the history update, and skips the divide when no frame has
//   been counted
// a clear produces no word and empties the frame history in order with
//   the jobs around it
// reset clears the frame in progress, the history and the output register
// when the receiver stalls the back end holds a finished word until the
//   output register frees, then the queue fills and full rises
module spectrum_peak_energy_average (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      command_i,
  input  logic [spea_pkg::IN_BITS-1:0]    intensity_i,
  input  logic                            last_i,
  output logic                            empty,
  input  logic                            pop,
  output logic                            kind_o,
  output logic [spea_pkg::VALUE_BITS-1:0] value_o,
  output logic                            frame_counted_o
);

  logic           accept;
  logic           q_push;
  spea_pkg::job_t q_job_in;
  logic           q_full;
  logic           q_pop;
  spea_pkg::job_t q_job_out;
  logic           q_empty;

  // the front never stalls except on a full job queue
  assign full   = q_full;
  assign accept = push && !q_full;

  spea_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .intensity_i (intensity_i),
    .last_i      (last_i),
    .q_push_o    (q_push),
    .q_job_o     (q_job_in)
  );

  spea_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_job_out),
    .empty_o (q_empty)
  );

  // root, history and average
  spea_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_job_i         (q_job_out),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .kind_o          (kind_o),
    .value_o         (value_o),
    .frame_counted_o (frame_counted_o)
  );

endmodule

// ===== verif/tb_spectrum_peak_energy_average.sv =====
module tb_spectrum_peak_energy_average;
  timeunit 1ns;
  timeprecision 1ps;

  // command code the block has no use for, must be dropped silently
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic                            kind;
    logic [spea_pkg::VALUE_BITS-1:0] value;
    logic                            counted;
  } energy_word_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            push;
  logic                            full;
  logic [1:0]                      command_i;
  logic [spea_pkg::IN_BITS-1:0]    intensity_i;
  logic                            last_i;
  logic                            empty;
  logic                            pop;
  logic                            kind_o;
  logic [spea_pkg::VALUE_BITS-1:0] value_o;
  logic                            frame_counted_o;

  spectrum_peak_energy_average dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .intensity_i     (intensity_i),
    .last_i          (last_i),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind_o),
    .value_o         (value_o),
    .frame_counted_o (frame_counted_o)
  );

  // own copy of the peak tracker and the frame history
  logic [spea_pkg::SAMPLE_BITS-1:0] older_smp;
  logic [spea_pkg::SAMPLE_BITS-1:0] newer_smp;
  logic [1:0]                       smp_held;
  logic [spea_pkg::SQ_BITS-1:0]     peak_sq_sum;
  logic [spea_pkg::HSUM_BITS-1:0]   frame_sum;
  logic [spea_pkg::COUNT_BITS-1:0]  frame_cnt;

  // words the block still owes us, oldest first
  energy_word_t pending_energy[$];

  int  n_words_in;
  int  n_frame_words;
  int  n_avg_words;
  int  n_fail;
  bit  tx_gaps_on;
  bit  rx_stalls_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  // mostly short idles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // bit-at-a-time floor root, tries each root bit from the top
  function automatic logic [spea_pkg::SQ_BITS/2-1:0] floor_root(
    input logic [spea_pkg::SQ_BITS-1:0] x);
    logic [spea_pkg::SQ_BITS/2-1:0] r;
    logic [spea_pkg::SQ_BITS/2-1:0] t;
    r = '0;
    for (int i = spea_pkg::SQ_BITS/2 - 1; i >= 0; i--) begin
      t = r;
      t[i] = 1'b1;
      if (longint'(t) * longint'(t) <= longint'(x)) r = t;
    end
    return r;
  endfunction

  // update the tracker for one accepted word and queue the word it owes
  task automatic track_peak_energy(input logic [1:0] cmd,
                                   input logic [spea_pkg::IN_BITS-1:0] sample,
                                   input logic fin);
    energy_word_t                   w;
    logic [spea_pkg::SQ_BITS:0]     acc;
    logic [spea_pkg::SQ_BITS/2-1:0] root;
    logic [spea_pkg::HSUM_BITS-1:0] avg;
    case (cmd)
      spea_pkg::CMD_SAMPLE: begin
        // middle sample beats both neighbours of the same frame
        if (smp_held == 2'd2 && newer_smp > older_smp &&
            newer_smp > sample[spea_pkg::SAMPLE_BITS-1:0]) begin
          acc = {1'b0, peak_sq_sum} + (spea_pkg::SQ_BITS+1)'(newer_smp)
                * (spea_pkg::SQ_BITS+1)'(newer_smp);
          peak_sq_sum = acc[spea_pkg::SQ_BITS] ? {spea_pkg::SQ_BITS{1'b1}}
                        : acc[spea_pkg::SQ_BITS-1:0];
        end
        older_smp = newer_smp;
        newer_smp = sample[spea_pkg::SAMPLE_BITS-1:0];
        if (smp_held != 2'd2) smp_held++;
        if (fin) begin
          root = floor_root(peak_sq_sum);
          w.kind = spea_pkg::KIND_FRAME;
          w.value = (root > {spea_pkg::VALUE_BITS{1'b1}}) ? {spea_pkg::VALUE_BITS{1'b1}}
                    : root[spea_pkg::VALUE_BITS-1:0];
          // zero frames and a full history leave the history alone
          w.counted = (w.value != '0) && (frame_cnt != {spea_pkg::COUNT_BITS{1'b1}});
          if (w.counted) begin
            frame_sum += w.value;
            frame_cnt++;
          end
          pending_energy.push_back(w);
          older_smp = '0;
          newer_smp = '0;
          smp_held = '0;
          peak_sq_sum = '0;
        end
      end
      spea_pkg::CMD_REPORT: begin
        avg = (frame_cnt == '0) ? '0 : frame_sum / frame_cnt;
        w.kind = spea_pkg::KIND_AVG;
        w.value = avg[spea_pkg::VALUE_BITS-1:0];
        w.counted = 1'b0;
        pending_energy.push_back(w);
      end
      spea_pkg::CMD_CLEAR: begin
        frame_sum = '0;
        frame_cnt = '0;
      end
      default: ;
    endcase
  endtask

  // one word into the block, preceded by an optional idle stretch
  task automatic send_word(input logic [1:0] cmd, input logic [spea_pkg::IN_BITS-1:0] sample,
                           input logic fin);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      // junk on the payload while push is low
      command_i <= 2'($urandom);
      intensity_i <= spea_pkg::IN_BITS'($urandom);
      last_i <= 1'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    command_i <= cmd;
    intensity_i <= sample;
    last_i <= fin;
    do @(posedge clk_i); while (full);
    track_peak_energy(cmd, sample, fin);
    n_words_in++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  task automatic note_failure(input string why, input energy_word_t want, input energy_word_t got);
    n_fail++;
    if (n_fail <= 10)
      $display("%s: expected kind %0d value %0d counted %0d, got kind %0d value %0d counted %0d",
               why, want.kind, want.value, want.counted, got.kind, got.value, got.counted);
  endtask

  // receiver: pop held high for runs, broken up by random stalls
  initial begin
    int stall;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      @(negedge clk_i);
      pop <= 1'b1;
    end
  end

  // every word leaving the block is matched against the oldest expectation
  always @(posedge clk_i) begin : check_words
    energy_word_t got;
    energy_word_t want;
    if (rst_ni && pop && !empty) begin
      got = '{kind: kind_o, value: value_o, counted: frame_counted_o};
      if (got.kind == spea_pkg::KIND_AVG) n_avg_words++;
      else n_frame_words++;
      if (pending_energy.size() == 0) begin
        note_failure("word with nothing pending", '0, got);
      end else begin
        want = pending_energy.pop_front();
        if (got.kind !== want.kind || got.value !== want.value || got.counted !== want.counted)
          note_failure("word mismatch", want, got);
      end
    end
  end

  // frame edges, ties, zero frames, ignored fields and commands, report and clear
  task automatic test_frame_edges();
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    send_word(spea_pkg::CMD_REPORT, 16'hffff, 1'b1);     // nothing counted yet, last ignored
    send_word(spea_pkg::CMD_SAMPLE, 16'hffff, 1'b1);     // one-sample frame
    send_word(spea_pkg::CMD_SAMPLE, 16'h0000, 1'b0);     // two-sample frame
    send_word(spea_pkg::CMD_SAMPLE, 16'hffff, 1'b1);
    send_word(spea_pkg::CMD_SAMPLE, 16'd50, 1'b0);       // first sample never a peak
    send_word(spea_pkg::CMD_SAMPLE, 16'd10, 1'b0);
    send_word(spea_pkg::CMD_SAMPLE, 16'd0, 1'b1);
    send_word(spea_pkg::CMD_SAMPLE, 16'h0000, 1'b0);     // largest peak
    send_word(spea_pkg::CMD_SAMPLE, 16'hffff, 1'b0);
    send_word(spea_pkg::CMD_SAMPLE, 16'h0000, 1'b1);
    send_word(spea_pkg::CMD_SAMPLE, 16'd9, 1'b0);        // equal neighbours, no peak
    send_word(spea_pkg::CMD_SAMPLE, 16'd9, 1'b0);
    send_word(spea_pkg::CMD_SAMPLE, 16'd3, 1'b1);
    send_word(spea_pkg::CMD_SAMPLE, 16'd1, 1'b0);        // rising last sample is not a peak
    send_word(spea_pkg::CMD_SAMPLE, 16'd5, 1'b0);
    send_word(spea_pkg::CMD_SAMPLE, 16'd2, 1'b0);
    send_word(spea_pkg::CMD_SAMPLE, 16'd8, 1'b1);
    send_word(CMD_UNUSED, 16'hffff, 1'b1);               // dropped
    send_word(spea_pkg::CMD_SAMPLE, 16'd3, 1'b0);        // clear in mid frame keeps the frame
    send_word(spea_pkg::CMD_SAMPLE, 16'd6, 1'b0);
    send_word(spea_pkg::CMD_CLEAR, 16'hffff, 1'b1);
    send_word(spea_pkg::CMD_SAMPLE, 16'd1, 1'b1);
    send_word(spea_pkg::CMD_SAMPLE, 16'd4, 1'b0);        // report in mid frame keeps the frame
    send_word(spea_pkg::CMD_SAMPLE, 16'd9, 1'b0);
    send_word(spea_pkg::CMD_REPORT, 16'h0000, 1'b0);
    send_word(spea_pkg::CMD_SAMPLE, 16'd2, 1'b1);
    send_word(spea_pkg::CMD_REPORT, 16'h0000, 1'b0);
    stop_sending();
  endtask

  // frames of one or more full-scale peaks back to back, large roots and averages
  task automatic test_wide_frames();
    int n_peaks[3];
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b1;
    n_peaks = '{1, 3, 40};
    foreach (n_peaks[k]) begin
      send_word(spea_pkg::CMD_SAMPLE, 16'h0000, 1'b0);
      repeat (n_peaks[k]) begin
        send_word(spea_pkg::CMD_SAMPLE, 16'hffff, 1'b0);
        send_word(spea_pkg::CMD_SAMPLE, 16'h0000, 1'b0);
      end
      send_word(spea_pkg::CMD_SAMPLE, 16'h0000, 1'b1);
    end
    send_word(spea_pkg::CMD_REPORT, 16'h0000, 1'b0);
    stop_sending();
  endtask

  function automatic logic [spea_pkg::IN_BITS-1:0] draw_sample(input int style);
    case (style)
      0: return spea_pkg::IN_BITS'($urandom_range(0, 3));             // lots of ties
      1: return spea_pkg::IN_BITS'(16'hffff - $urandom_range(0, 3));  // near full scale
      2: return 16'(1) << $urandom_range(0, 15);                      // walking bit
      default: return spea_pkg::IN_BITS'($urandom);
    endcase
  endfunction

  // mostly whole frames with random content, plus commands and stray words
  task automatic test_random_traffic();
    int start;
    int flen;
    int style;
    int r;
    start = n_words_in;
    while (n_words_in - start < 850) begin
      // switch between idling and back-to-back traffic now and then
      if ($urandom_range(0, 15) == 0) begin
        tx_gaps_on = ($urandom_range(0, 2) != 0);
        rx_stalls_on = ($urandom_range(0, 2) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 80) begin
        flen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        style = $urandom_range(0, 4);
        for (int i = 0; i < flen; i++) begin
          if ($urandom_range(0, 29) == 0)
            send_word(($urandom_range(0, 1) != 0) ? spea_pkg::CMD_REPORT : spea_pkg::CMD_CLEAR,
                      spea_pkg::IN_BITS'($urandom), 1'($urandom));
          send_word(spea_pkg::CMD_SAMPLE, draw_sample(style), i == flen - 1);
        end
      end else if (r < 88) begin
        send_word(spea_pkg::CMD_REPORT, spea_pkg::IN_BITS'($urandom), 1'($urandom));
      end else if (r < 93) begin
        send_word(spea_pkg::CMD_CLEAR, spea_pkg::IN_BITS'($urandom), 1'($urandom));
      end else if (r < 96) begin
        send_word(CMD_UNUSED, spea_pkg::IN_BITS'($urandom), 1'($urandom));
      end else begin
        // loose samples with frame ends at random
        repeat ($urandom_range(1, 6))
          send_word(spea_pkg::CMD_SAMPLE, spea_pkg::IN_BITS'($urandom),
                    $urandom_range(0, 3) == 0);
      end
    end
    stop_sending();
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    command_i = spea_pkg::CMD_SAMPLE;
    intensity_i = '0;
    last_i = 1'b0;
    older_smp = '0;
    newer_smp = '0;
    smp_held = '0;
    peak_sq_sum = '0;
    frame_sum = '0;
    frame_cnt = '0;
    n_words_in = 0;
    n_frame_words = 0;
    n_avg_words = 0;
    n_fail = 0;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_frame_edges();
    test_wide_frames();
    test_random_traffic();

    // drain what is still owed, then give a clear or a report time to settle
    rx_stalls_on = 1'b1;
    while (pending_energy.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("run covered %0d input words: frame edges, full-scale peaks, random traffic",
             n_words_in);
    $display("checked %0d frame words and %0d average words, %0d failures",
             n_frame_words, n_avg_words, n_fail);
    if (n_fail == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
